@@ rtl/core/tqfs_pkg.sv @@
package tqfs_pkg;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_LEAD  = 8'hE2;
  localparam logic [7:0] CH_MID   = 8'h80;
  localparam logic [7:0] CH_OPEN  = 8'h9C;
  localparam logic [7:0] CH_CLOSE = 8'h9D;

  localparam logic [1:0] KIND_DATA    = 2'd0;
  localparam logic [1:0] KIND_FIELD   = 2'd1;
  localparam logic [1:0] KIND_RECORD  = 2'd2;
  localparam logic [1:0] KIND_UNTERM  = 2'd3;

  localparam logic [1:0] MATCH_NONE = 2'd0;
  localparam logic [1:0] MATCH_LEAD = 2'd1;
  localparam logic [1:0] MATCH_MID  = 2'd2;

  localparam int unsigned MAX_RES = 4;

  typedef struct packed {
    logic       quoted_mode;
    logic       quote_pending;
    logic [1:0] match_cnt;
    logic       line_open;
  } parse_st_t;

  typedef struct packed {
    parse_st_t             st;
    logic [2:0]            n;
    logic [MAX_RES-1:0][7:0] bytes;
    logic [MAX_RES-1:0][1:0] kinds;
  } work_t;

  function automatic work_t emit(input work_t w, input logic [7:0] b, input logic [1:0] k);
    work_t r;
    r = w;
    if (r.n < 3'(MAX_RES)) begin
      r.bytes[r.n[1:0]] = b;
      r.kinds[r.n[1:0]] = k;
      r.n = r.n + 3'd1;
    end
    return r;
  endfunction

  function automatic work_t feed_plain(input work_t w, input logic [7:0] c);
    work_t r;
    r = w;
    if (c == CH_QUOTE) begin
      r = emit(r, CH_QUOTE, KIND_DATA);
      r.st.quote_pending = !r.st.quote_pending;
      r.st.line_open = 1'b1;
    end else begin
      // A pending quote followed by anything else was a lone quote.
      if (r.st.quote_pending) begin
        r.st.quoted_mode = !r.st.quoted_mode;
        r.st.quote_pending = 1'b0;
      end
      if (c == CH_TAB && !r.st.quoted_mode) begin
        r = emit(r, 8'h00, KIND_FIELD);
        r.st.line_open = 1'b1;
      end else if (c == CH_NL && !r.st.quoted_mode) begin
        r = emit(r, 8'h00, KIND_RECORD);
        r.st.line_open = 1'b0;
      end else begin
        r = emit(r, c, KIND_DATA);
        r.st.line_open = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic work_t feed_fresh(input work_t w, input logic [7:0] c);
    work_t r;
    r = w;
    if (c == CH_LEAD) begin
      r.st.match_cnt = MATCH_LEAD;
      r.st.line_open = 1'b1;
    end else begin
      r = feed_plain(r, c);
    end
    return r;
  endfunction

  function automatic work_t flush_held(input work_t w);
    work_t      r;
    logic [1:0] held;
    r = w;
    held = r.st.match_cnt;
    r.st.match_cnt = MATCH_NONE;
    if (held != MATCH_NONE) begin
      r = feed_plain(r, CH_LEAD);
    end
    if (held != MATCH_NONE && held != MATCH_LEAD) begin
      r = feed_plain(r, CH_MID);
    end
    return r;
  endfunction

  function automatic work_t parse_step(input parse_st_t s, input logic [7:0] c,
                                       input logic eos);
    work_t r;
    r = '0;
    r.st = s;
    case (s.match_cnt)
      MATCH_NONE: begin
        r = feed_fresh(r, c);
      end
      MATCH_LEAD: begin
        if (c == CH_MID) begin
          r.st.match_cnt = MATCH_MID;
        end else begin
          r = flush_held(r);
          r = feed_fresh(r, c);
        end
      end
      default: begin
        // A completed smart quote is a doubled pair, so it leaves the pending flag alone.
        if (c == CH_OPEN || c == CH_CLOSE) begin
          r.st.match_cnt = MATCH_NONE;
          r = emit(r, CH_QUOTE, KIND_DATA);
          r = emit(r, CH_QUOTE, KIND_DATA);
          r.st.line_open = 1'b1;
        end else begin
          r = flush_held(r);
          r = feed_fresh(r, c);
        end
      end
    endcase
    if (eos) begin
      r = flush_held(r);
      if (r.st.quote_pending) begin
        r.st.quoted_mode = !r.st.quoted_mode;
        r.st.quote_pending = 1'b0;
      end
      if (r.st.quoted_mode) begin
        r = emit(r, 8'h00, KIND_UNTERM);
      end else if (r.st.line_open) begin
        r = emit(r, 8'h00, KIND_RECORD);
      end
      r.st = '0;
    end
    return r;
  endfunction

endpackage

@@ rtl/core/tsv_quoted_field_splitter_top.sv @@
// Tab-separated field splitter with quote handling.
// Input channel: one text byte per transfer on in_byte, with in_end_of_stream
// marking the final byte of a file. Output channel: one result per transfer,
// out_kind telling a data byte, a field end, a record end or an unterminated
// record, and out_last_of_run flagging the last result caused by one byte.
// A byte may cause zero to four results; most cause exactly one.
// The accepted byte sits in an input register and is parsed in one pass into a
// four-entry result buffer once that buffer is free; results leave from there.
// Throughput is one byte per cycle while each byte gives at most one result and
// out_stall stays low; a byte with more than one result holds the result buffer
// until its last result transfers, and the input register takes one more byte
// meanwhile before in_stall rises.
// When out_stall is high the current result holds and the input backs up.
// Reset (rst_n low, synchronous) empties both registers and returns the parser
// to unquoted mode with no held bytes and no open line. After a byte marked
// end of stream the parser state likewise returns to its reset values.
module tsv_quoted_field_splitter_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_stream,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic [1:0] out_kind,
  output logic       out_last_of_run
);

  logic                 inq_v_r;
  logic [7:0]           inq_byte_r;
  logic                 inq_eos_r;
  tqfs_pkg::parse_st_t  st_r;
  tqfs_pkg::work_t      work;
  logic [7:0]           res_byte_r [tqfs_pkg::MAX_RES];
  logic [1:0]           res_kind_r [tqfs_pkg::MAX_RES];
  logic [1:0]           pos_r;
  logic [2:0]           rem_r;
  logic                 buf_free;
  logic                 process;
  logic                 in_take;

  // The buffer frees up when it is empty or its last result transfers now.
  assign buf_free = (rem_r == 3'd0) || (rem_r == 3'd1 && !out_stall);
  assign process  = inq_v_r && buf_free;
  assign in_stall = inq_v_r && !process;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    work = tqfs_pkg::parse_step(st_r, inq_byte_r, inq_eos_r);
  end

  assign out_valid       = rem_r != 3'd0;
  assign out_byte        = res_byte_r[pos_r];
  assign out_kind        = res_kind_r[pos_r];
  assign out_last_of_run = rem_r == 3'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inq_v_r <= 1'b0;
      st_r    <= '0;
      rem_r   <= 3'd0;
      pos_r   <= 2'd0;
    end else begin
      if (in_take) begin
        inq_v_r <= 1'b1;
      end else if (process) begin
        inq_v_r <= 1'b0;
      end
      if (process) begin
        st_r  <= work.st;
        rem_r <= work.n;
        pos_r <= 2'd0;
      end else if (out_valid && !out_stall) begin
        rem_r <= rem_r - 3'd1;
        pos_r <= pos_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      inq_byte_r <= in_byte;
      inq_eos_r  <= in_end_of_stream;
    end
    if (process) begin
      for (int i = 0; i < tqfs_pkg::MAX_RES; i++) begin
        res_byte_r[i] <= work.bytes[i];
        res_kind_r[i] <= work.kinds[i];
      end
    end
  end

endmodule
